>>> sv/dmd_pkg.sv
`default_nettype none
package dmd_pkg;

    localparam int ROW_COUNT    = 7;
    localparam int COLUMN_COUNT = 5;
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] FRAME_EVEN = 8'b0001_0101;
    localparam logic [7:0] FRAME_ODD  = 8'b0000_1010;

    localparam logic [3:0] OPC_SCAN      = 4'd0;
    localparam logic [3:0] OPC_PIX_READ  = 4'd1;
    localparam logic [3:0] OPC_PIX_SET   = 4'd2;
    localparam logic [3:0] OPC_PIX_CLR   = 4'd3;
    localparam logic [3:0] OPC_ROW_READ  = 4'd4;
    localparam logic [3:0] OPC_ROW_WRITE = 4'd5;
    localparam logic [3:0] OPC_ROW_CLR   = 4'd6;
    localparam logic [3:0] OPC_CLR_ALL   = 4'd7;
    localparam logic [3:0] OPC_SHIFT     = 4'd8;
    localparam logic [3:0] OPC_STORE     = 4'd9;
    localparam logic [3:0] OPC_RENDER    = 4'd10;
    localparam logic [3:0] OPC_WIN_FWD   = 4'd11;
    localparam logic [3:0] OPC_WIN_BACK  = 4'd12;

    typedef enum logic [3:0] {
        K_SCAN,
        K_PIX_READ,
        K_PIX_SET,
        K_PIX_CLR,
        K_ROW_READ,
        K_ROW_WRITE,
        K_ROW_CLR,
        K_CLR_ALL,
        K_SHIFT,
        K_STORE,
        K_RENDER,
        K_WIN_FWD,
        K_WIN_BACK,
        K_NONE
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  row;
        logic [7:0]  mask;
        logic [5:0]  bidx;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data_out;
        logic [2:0] row_index;
        logic       can_move_forward;
        logic       can_move_back;
        logic [5:0] window_position;
        logic       last;
    } t_result;

    function automatic logic [7:0] scan_pattern(input logic [7:0] row_bits);
        logic [7:0] p;
        p = '0;
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            p[c] = row_bits[COLUMN_COUNT-1-c];
        end
        return p;
    endfunction

    function automatic logic [7:0] frame_reset(input int r);
        return (r % 2 == 1) ? FRAME_ODD : FRAME_EVEN;
    endfunction

endpackage
`default_nettype wire

>>> sv/dmd_if.sv
`default_nettype none
interface dmd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [2:0] row;
    logic [2:0] col;
    logic [5:0] buffer_index;
    logic [7:0] data_in;

    modport source (output valid, opcode, row, col, buffer_index, data_in, input ready);
    modport sink   (input valid, opcode, row, col, buffer_index, data_in, output ready);
endinterface

interface dmd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [2:0] row_index;
    logic       can_move_forward;
    logic       can_move_back;
    logic [5:0] window_position;
    logic       last;

    modport source (output valid, data_out, row_index, can_move_forward, can_move_back,
                    window_position, last, input ready);
    modport sink   (input valid, data_out, row_index, can_move_forward, can_move_back,
                    window_position, last, output ready);
endinterface
`default_nettype wire

>>> sv/dmd_ram.sv
`default_nettype none
module dmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/dmd_front.sv
`default_nettype none
module dmd_front (
    dmd_in_if.sink          i_in,
    input  wire logic       i_full,
    output logic            o_push,
    output dmd_pkg::t_cmd   o_cmd
);
    import dmd_pkg::*;

    logic row_ok;
    logic pix_ok;
    logic bidx_ok;
    t_kind kind;

    assign row_ok  = int'(i_in.row) < ROW_COUNT;
    assign pix_ok  = row_ok && (int'(i_in.col) < COLUMN_COUNT);
    assign bidx_ok = int'(i_in.buffer_index) < STORE_DEPTH;

    // out-of-range accesses fold into a plain result
    always_comb begin
        case (i_in.opcode)
            OPC_SCAN:      kind = K_SCAN;
            OPC_PIX_READ:  kind = pix_ok ? K_PIX_READ : K_NONE;
            OPC_PIX_SET:   kind = pix_ok ? K_PIX_SET : K_NONE;
            OPC_PIX_CLR:   kind = pix_ok ? K_PIX_CLR : K_NONE;
            OPC_ROW_READ:  kind = row_ok ? K_ROW_READ : K_NONE;
            OPC_ROW_WRITE: kind = row_ok ? K_ROW_WRITE : K_NONE;
            OPC_ROW_CLR:   kind = row_ok ? K_ROW_CLR : K_NONE;
            OPC_CLR_ALL:   kind = K_CLR_ALL;
            OPC_SHIFT:     kind = K_SHIFT;
            OPC_STORE:     kind = bidx_ok ? K_STORE : K_NONE;
            OPC_RENDER:    kind = K_RENDER;
            OPC_WIN_FWD:   kind = K_WIN_FWD;
            OPC_WIN_BACK:  kind = K_WIN_BACK;
            default:       kind = K_NONE;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd.kind = kind;
        o_cmd.row  = i_in.row;
        o_cmd.mask = 8'd1 << (3'(COLUMN_COUNT - 1) - i_in.col);
        o_cmd.bidx = i_in.buffer_index;
        o_cmd.data = i_in.data_in;
    end
endmodule
`default_nettype wire

>>> sv/dmd_queue.sv
`default_nettype none
module dmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dmd_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output dmd_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import dmd_pkg::*;

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W-1:0] n_rd;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    assign o_full  = int'(r_count) == QUEUE_DEPTH;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_buf[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

>>> sv/dmd_back.sv
`default_nettype none
module dmd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [5:0]    i_cfg_data,
    input  wire logic          i_cmd_valid,
    input  wire dmd_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    dmd_out_if.source          o_out
);
    import dmd_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_cmd       r_cmd;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [7:0] r_frame [ROW_COUNT];
    logic [7:0] n_frame [ROW_COUNT];
    logic [5:0] r_ws;
    logic [5:0] n_ws;
    logic [5:0] r_lbc;
    logic       r_stored [STORE_DEPTH];
    logic       r_rd_ok;
    logic       n_rd_ok;
    t_result    r_out;
    t_result    n_out;
    logic       r_out_valid;

    logic                slot_free;
    logic                out_load;
    logic                fwd_ok;
    logic                back_ok;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;
    logic [6:0]          rd_idx;
    logic [7:0]          store_byte;
    logic [7:0]          col_bit;

    dmd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free  = !r_out_valid || o_out.ready;
    assign fwd_ok     = ({1'b0, r_ws} + 7'(COLUMN_COUNT - 1)) < {1'b0, r_lbc};
    assign back_ok    = r_ws != 6'd0;
    assign rd_idx     = {1'b0, r_ws} + {4'd0, r_cnt};
    assign ram_raddr  = STORE_AW'(rd_idx);
    assign ram_waddr  = STORE_AW'(i_cmd.bidx);
    assign store_byte = r_rd_ok ? ram_rdata : 8'd0;
    assign col_bit    = 8'd1 << (3'(COLUMN_COUNT - 1) - r_cnt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_SCAN:   n_state = ST_SCAN;
                        K_RENDER: n_state = ST_RD_ADDR;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (slot_free && (int'(r_cnt) == ROW_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ADDR: n_state = ST_RD_DATA;
            ST_RD_DATA: begin
                if (int'(r_cnt) == COLUMN_COUNT - 1) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_RD_ADDR;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
        ram_we    = o_cmd_pop && (i_cmd.kind == K_STORE);
        out_load  = slot_free && ((r_state == ST_SCAN) || (r_state == ST_EMIT));

        n_out.can_move_forward = fwd_ok;
        n_out.can_move_back    = back_ok;
        n_out.window_position  = r_ws;
        if (r_state == ST_SCAN) begin
            n_out.data_out  = scan_pattern(r_frame[r_cnt]);
            n_out.row_index = r_cnt;
            n_out.last      = int'(r_cnt) == ROW_COUNT - 1;
        end else begin
            case (r_cmd.kind)
                K_PIX_READ: n_out.data_out = {7'd0, |(r_frame[r_cmd.row] & r_cmd.mask)};
                K_ROW_READ: n_out.data_out = r_frame[r_cmd.row];
                default:    n_out.data_out = 8'd0;
            endcase
            n_out.row_index = r_cmd.row;
            n_out.last      = 1'b1;
        end
    end

    always_comb begin
        n_frame = r_frame;
        n_ws    = r_ws;
        n_cnt   = r_cnt;
        n_rd_ok = r_rd_ok;
        case (r_state)
            ST_IDLE: begin
                n_cnt = 3'd0;
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_PIX_SET:   n_frame[i_cmd.row] = r_frame[i_cmd.row] | i_cmd.mask;
                        K_PIX_CLR:   n_frame[i_cmd.row] = r_frame[i_cmd.row] & ~i_cmd.mask;
                        K_ROW_WRITE: n_frame[i_cmd.row] = i_cmd.data;
                        K_ROW_CLR:   n_frame[i_cmd.row] = 8'd0;
                        K_CLR_ALL, K_RENDER: begin
                            for (int r = 0; r < ROW_COUNT; r++) begin
                                n_frame[r] = 8'd0;
                            end
                        end
                        K_SHIFT: begin
                            for (int r = ROW_COUNT - 1; r > 0; r--) begin
                                n_frame[r] = r_frame[r-1];
                            end
                            n_frame[0] = 8'd0;
                        end
                        K_WIN_FWD: begin
                            if (fwd_ok) begin
                                n_ws = r_ws + 6'd1;
                            end
                        end
                        K_WIN_BACK: begin
                            if (back_ok) begin
                                n_ws = r_ws - 6'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (slot_free) begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_RD_ADDR: begin
                n_rd_ok = (int'(rd_idx) < STORE_DEPTH) && r_stored[ram_raddr];
            end
            ST_RD_DATA: begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    if (store_byte[ROW_COUNT-1-r]) begin
                        n_frame[r] = r_frame[r] | col_bit;
                    end
                end
                n_cnt = r_cnt + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 3'd0;
            r_ws        <= 6'd0;
            r_lbc       <= 6'd0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_frame[r] <= frame_reset(r);
            end
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_stored[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ws    <= n_ws;
            r_frame <= n_frame;
            if (i_cfg_we) begin
                r_lbc <= i_cfg_data;
            end
            if (ram_we) begin
                r_stored[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_rd_ok <= n_rd_ok;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.data_out         = r_out.data_out;
    assign o_out.row_index        = r_out.row_index;
    assign o_out.can_move_forward = r_out.can_move_forward;
    assign o_out.can_move_back    = r_out.can_move_back;
    assign o_out.window_position  = r_out.window_position;
    assign o_out.last             = r_out.last;
endmodule
`default_nettype wire

>>> sv/dot_matrix_display_controller.sv
// Single-result opcodes give one registered result per command; a scan gives its rows
// one per cycle while the output is ready, ending with last on the final row.
// A render reads and merges one store column at a time, an address state then a data
// state per column; the back end takes the next command only once back in idle.
// Reset: frame to checkerboard, column store reads zero through per-entry valid
// bits, window start and last column zero; no clearing pass.
`default_nettype none
module dot_matrix_display_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_data,
    dmd_in_if.sink          i_in,
    dmd_out_if.source       o_out
);
    import dmd_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    dmd_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    dmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    dmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

>>> sv/dmd_checker.sv
`default_nettype none
module dmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_data_out,
    input wire logic [2:0] i_row_index,
    input wire logic       i_can_move_back,
    input wire logic [5:0] i_window_position,
    input wire logic       i_last
);
    import dmd_pkg::*;

    logic out_fire;
    assign out_fire = i_out_valid && i_out_ready;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out)
            && $stable(i_row_index) && $stable(i_last))
        else $error("result changed while stalled");

    a_back_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_can_move_back == (i_window_position != 6'd0)))
        else $error("back flag disagrees with window position");

    a_scan_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> int'(i_row_index) < ROW_COUNT - 1)
        else $error("non-final scan row out of range");

    a_scan_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !i_last |=> i_out_valid
            && (i_row_index == $past(i_row_index) + 3'd1))
        else $error("scan rows not back to back");
endmodule

bind dot_matrix_display_controller dmd_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_data_out        (o_out.data_out),
    .i_row_index       (o_out.row_index),
    .i_can_move_back   (o_out.can_move_back),
    .i_window_position (o_out.window_position),
    .i_last            (o_out.last)
);
`default_nettype wire

>>> sim/tb_dot_matrix_display_controller.sv
`default_nettype none
module tb_dot_matrix_display_controller;
    import dmd_pkg::*;

    localparam logic [3:0] OPC_UNDEF_FIRST = OPC_WIN_BACK + 4'd1;
    localparam logic [3:0] OPC_UNDEF_LAST  = 4'hF;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         PHASES          = 4;

    typedef struct {
        logic [3:0] opcode;
        logic [2:0] row;
        logic [2:0] col;
        logic [5:0] buffer_index;
        logic [7:0] data_in;
    } t_panel_cmd;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_data;

    dmd_in_if  in_if ();
    dmd_out_if out_if ();

    dot_matrix_display_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // shadow copy of the panel
    logic [7:0] panel_rows [ROW_COUNT];
    logic [7:0] column_bytes [STORE_DEPTH];
    logic [5:0] win_start;
    logic [5:0] last_col;
    int         win_peak;

    t_panel_cmd cmd_backlog [$];
    t_result    due_results [$];
    t_panel_cmd offered;
    logic       offering;
    int         tx_gap;
    int         rx_stall;
    logic       rx_hold;
    logic       hold_go;
    logic       no_idle;
    int         errors;
    int         cmds_done;
    int         results_done;
    int         cycle_count;

    initial begin
        i_clk = 1'b0;
    end
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] col_bit(input int c);
        return 8'h01 << (COLUMN_COUNT - 1 - c);
    endfunction

    function automatic logic window_can_advance();
        return (int'(win_start) + COLUMN_COUNT - 1) < int'(last_col);
    endfunction

    task automatic push_result(input logic [7:0] value, input logic [2:0] row_idx,
                               input logic is_last);
        t_result res;
        res.data_out         = value;
        res.row_index        = row_idx;
        res.can_move_forward = window_can_advance();
        res.can_move_back    = (win_start != 6'd0);
        res.window_position  = win_start;
        res.last             = is_last;
        due_results.push_back(res);
    endtask

    task automatic execute_panel_cmd(input t_panel_cmd cmd);
        logic [7:0] value;
        logic [7:0] pattern;
        logic [7:0] cb;
        logic       row_ok;
        logic       pix_ok;
        int         idx;
        value  = 8'h00;
        row_ok = (cmd.row < ROW_COUNT);
        pix_ok = row_ok && (cmd.col < COLUMN_COUNT);
        if (cmd.opcode == OPC_SCAN) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                pattern = 8'h00;
                for (int c = 0; c < COLUMN_COUNT; c++) begin
                    pattern[c] = |(panel_rows[r] & col_bit(c));
                end
                push_result(pattern, 3'(r), r == ROW_COUNT - 1);
            end
            return;
        end
        case (cmd.opcode)
            OPC_PIX_READ: begin
                if (pix_ok) value = {7'd0, |(panel_rows[cmd.row] & col_bit(cmd.col))};
            end
            OPC_PIX_SET: begin
                if (pix_ok) panel_rows[cmd.row] = panel_rows[cmd.row] | col_bit(cmd.col);
            end
            OPC_PIX_CLR: begin
                if (pix_ok) panel_rows[cmd.row] = panel_rows[cmd.row] & ~col_bit(cmd.col);
            end
            OPC_ROW_READ: begin
                if (row_ok) value = panel_rows[cmd.row];
            end
            OPC_ROW_WRITE: begin
                if (row_ok) panel_rows[cmd.row] = cmd.data_in;
            end
            OPC_ROW_CLR: begin
                if (row_ok) panel_rows[cmd.row] = 8'h00;
            end
            OPC_CLR_ALL: begin
                for (int r = 0; r < ROW_COUNT; r++) panel_rows[r] = 8'h00;
            end
            OPC_SHIFT: begin
                for (int r = ROW_COUNT - 1; r > 0; r--) panel_rows[r] = panel_rows[r-1];
                panel_rows[0] = 8'h00;
            end
            OPC_STORE: begin
                column_bytes[cmd.buffer_index] = cmd.data_in;
            end
            OPC_RENDER: begin
                for (int r = 0; r < ROW_COUNT; r++) panel_rows[r] = 8'h00;
                for (int c = 0; c < COLUMN_COUNT; c++) begin
                    idx = int'(win_start) + c;
                    cb  = (idx < STORE_DEPTH) ? column_bytes[idx] : 8'h00;
                    for (int r = 0; r < ROW_COUNT; r++) begin
                        if (cb[ROW_COUNT-1-r]) panel_rows[r] = panel_rows[r] | col_bit(c);
                    end
                end
            end
            OPC_WIN_FWD: begin
                if (window_can_advance()) win_start = win_start + 6'd1;
            end
            OPC_WIN_BACK: begin
                if (win_start != 6'd0) win_start = win_start - 6'd1;
            end
            default: begin
            end
        endcase
        if (int'(win_start) > win_peak) win_peak = int'(win_start);
        push_result(value, cmd.row, 1'b1);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 100) begin
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     results_done, what, got, want);
        end
        errors++;
    endtask

    task automatic check_result();
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected transaction", out_if.data_out, 0);
            return;
        end
        want = due_results.pop_front();
        if (out_if.data_out !== want.data_out)
            report_mismatch("data_out", out_if.data_out, want.data_out);
        if (out_if.row_index !== want.row_index)
            report_mismatch("row_index", out_if.row_index, want.row_index);
        if (out_if.can_move_forward !== want.can_move_forward)
            report_mismatch("can_move_forward", out_if.can_move_forward,
                            want.can_move_forward);
        if (out_if.can_move_back !== want.can_move_back)
            report_mismatch("can_move_back", out_if.can_move_back, want.can_move_back);
        if (out_if.window_position !== want.window_position)
            report_mismatch("window_position", out_if.window_position,
                            want.window_position);
        if (out_if.last !== want.last)
            report_mismatch("last", out_if.last, want.last);
    endtask

    task automatic queue_cmd(input logic [3:0] op, input logic [2:0] row,
                             input logic [2:0] col, input logic [5:0] bidx,
                             input logic [7:0] data);
        t_panel_cmd cmd;
        cmd.opcode       = op;
        cmd.row          = row;
        cmd.col          = col;
        cmd.buffer_index = bidx;
        cmd.data_in      = data;
        cmd_backlog.push_back(cmd);
    endtask

    function automatic t_panel_cmd random_cmd(input int fwd_pct);
        t_panel_cmd cmd;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < fwd_pct)
            cmd.opcode = OPC_WIN_FWD;
        else if (pick < fwd_pct + 8)
            cmd.opcode = OPC_WIN_BACK;
        else if (pick < fwd_pct + 12)
            cmd.opcode = 4'($urandom_range(OPC_UNDEF_FIRST, OPC_UNDEF_LAST));
        else
            cmd.opcode = 4'($urandom_range(OPC_SCAN, OPC_WIN_BACK));
        cmd.row = ($urandom_range(0, 7) == 0) ? 3'd7 : 3'($urandom_range(0, ROW_COUNT - 1));
        cmd.col = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(COLUMN_COUNT, 7))
                                              : 3'($urandom_range(0, COLUMN_COUNT - 1));
        cmd.buffer_index = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom);
        cmd.data_in      = 8'($urandom);
        return cmd;
    endfunction

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || offering || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_last_col(input logic [5:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        last_col = value;
        @(negedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n || offering) begin
        end else if (tx_gap != 0 && !no_idle) begin
            in_if.valid <= 1'b0;
            tx_gap      <= tx_gap - 1;
        end else if (cmd_backlog.size() != 0) begin
            offered             = cmd_backlog[0];
            in_if.valid        <= 1'b1;
            in_if.opcode       <= offered.opcode;
            in_if.row          <= offered.row;
            in_if.col          <= offered.col;
            in_if.buffer_index <= offered.buffer_index;
            in_if.data_in      <= offered.data_in;
            offering           <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 16);
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            void'(cmd_backlog.pop_front());
            execute_panel_cmd(offered);
            offering <= 1'b0;
            cmds_done++;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rx_hold || (rx_stall != 0 && !no_idle)) begin
            out_if.ready <= 1'b0;
            if (rx_stall != 0) rx_stall <= rx_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) rx_stall <= $urandom_range(1, 16);
        end
    end

    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            check_result();
            results_done++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int limits [PHASES];
        int counts [PHASES];
        int fwd_pcts [PHASES];
        limits   = '{10, 63, 0, 6};
        counts   = '{20, 34, 15, 15};
        fwd_pcts = '{15, 45, 10, 15};
        in_if.valid        = 1'b0;
        in_if.opcode       = OPC_SCAN;
        in_if.row          = 3'd0;
        in_if.col          = 3'd0;
        in_if.buffer_index = 6'd0;
        in_if.data_in      = 8'h00;
        out_if.ready       = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = 6'd0;
        i_rst_n            = 1'b0;
        offering           = 1'b0;
        tx_gap             = 0;
        rx_stall           = 0;
        hold_go            = 1'b0;
        no_idle            = 1'b0;
        errors             = 0;
        cmds_done          = 0;
        results_done       = 0;
        cycle_count        = 0;
        win_start          = 6'd0;
        last_col           = 6'd0;
        win_peak           = 0;
        for (int r = 0; r < ROW_COUNT; r++) panel_rows[r] = (r % 2 == 1) ? 8'h0A : 8'h15;
        for (int i = 0; i < STORE_DEPTH; i++) column_bytes[i] = 8'h00;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset state, window pinned at zero
        queue_cmd(OPC_SCAN,        3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_PIX_READ,    3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_PIX_READ,    3'd7, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_PIX_READ,    3'd0, 3'd7, 6'd0, 8'h00);
        queue_cmd(OPC_WIN_FWD,     3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_WIN_BACK,    3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_UNDEF_FIRST, 3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_UNDEF_LAST,  3'd7, 3'd7, 6'h3F, 8'hFF);
        wait_idle();
        write_last_col(6'd63);
        queue_cmd(OPC_PIX_SET,     3'd3, 3'd2, 6'd0, 8'h00);
        queue_cmd(OPC_PIX_CLR,     3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_PIX_SET,     3'd1, 3'd5, 6'd0, 8'h00);
        queue_cmd(OPC_ROW_WRITE,   3'd6, 3'd0, 6'd0, 8'hFF);
        queue_cmd(OPC_ROW_WRITE,   3'd7, 3'd0, 6'd0, 8'hAA);
        queue_cmd(OPC_ROW_READ,    3'd6, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_ROW_READ,    3'd7, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_SCAN,        3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_SHIFT,       3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_ROW_CLR,     3'd2, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_STORE,       3'd0, 3'd0, 6'd0, 8'hFF);
        queue_cmd(OPC_STORE,       3'd0, 3'd0, 6'h3F, 8'h55);
        queue_cmd(OPC_STORE,       3'd0, 3'd0, 6'd4, 8'h2A);
        queue_cmd(OPC_RENDER,      3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_SCAN,        3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_CLR_ALL,     3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_WIN_FWD,     3'd0, 3'd0, 6'd0, 8'h00);
        queue_cmd(OPC_WIN_BACK,    3'd0, 3'd0, 6'd0, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_last_col(6'(limits[p]));
            if (p == PHASES - 1) no_idle = 1'b1;
            for (int n = 0; n < counts[p]; n++) cmd_backlog.push_back(random_cmd(fwd_pcts[p]));
            if (p == 1) hold_go = 1'b1;
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("ran %0d commands at limits 0, 63, 10, 63, 0 and 6 with a long", cmds_done);
        $display("output hold; %0d results checked, window start peaked at %0d",
                 results_done, win_peak);
        if (errors == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
sv/dmd_pkg.sv
sv/dmd_if.sv
sv/dmd_ram.sv
sv/dmd_front.sv
sv/dmd_queue.sv
sv/dmd_back.sv
sv/dot_matrix_display_controller.sv
sv/dmd_checker.sv
sim/tb_dot_matrix_display_controller.sv
